// ----- rtl/core/assert_macros.svh -----
// assertion macros for the encoder rtl, used by the symbol sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/ookd_pkg.sv -----
// types and constants of the ook dimmer frame encoder
`timescale 1ns / 1ps
package ookd_pkg;

    localparam int ID_W       = 26;
    localparam int UNIT_W     = 4;
    localparam int DIM_W      = 4;
    localparam int CMD_W      = 2;
    localparam int BASE_W     = 12;
    localparam int FACTOR_W   = 6;
    localparam int PULSE_W    = 18;
    localparam int COUNT_W    = 3;
    localparam int ERR_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int FRAME_BITS   = 36;
    localparam int SYMBOL_COUNT = 38;
    localparam int IDX_W        = 6;
    localparam int STATE_GROUP  = 27;
    localparam int START_FACTOR = 10;

    localparam logic [BASE_W-1:0]   BASE_PULSE_RST    = 12'd300;
    localparam logic [FACTOR_W-1:0] LONG_FACTOR_RST   = 6'd5;
    localparam logic [FACTOR_W-1:0] FOOTER_FACTOR_RST = 6'd34;
    localparam logic [DIM_W-1:0]    DIM_MIN_RST       = 4'd0;
    localparam logic [DIM_W-1:0]    DIM_MAX_RST       = 4'd15;

    localparam logic [COUNT_W-1:0] COUNT_NONE = 3'd0;
    localparam logic [COUNT_W-1:0] COUNT_PAIR = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_QUAD = 3'd4;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFF  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ON   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 3'd0,
        ERR_MISSING = 3'd1,
        ERR_BAD_ID  = 3'd2,
        ERR_BAD_DIM = 3'd3,
        ERR_DIM_OFF = 3'd4
    } t_err_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_PULSE    = 3'd0,
        CFG_LONG_FACTOR   = 3'd1,
        CFG_FOOTER_FACTOR = 3'd2,
        CFG_DIM_MIN       = 3'd3,
        CFG_DIM_MAX       = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ID_W-1:0]   device_id;
        logic              id_given;
        logic [UNIT_W-1:0] unit_code;
        logic              unit_given;
        logic              all_units;
        logic [CMD_W-1:0]  switch_cmd;
        logic [DIM_W-1:0]  dim_level;
        logic              dim_given;
    } t_cmd;

    typedef struct packed {
        logic [PULSE_W-1:0] short_pulse;
        logic [PULSE_W-1:0] start_pulse;
        logic [PULSE_W-1:0] long_pulse;
        logic [PULSE_W-1:0] footer_pulse;
        logic [DIM_W-1:0]   dim_min;
        logic [DIM_W-1:0]   dim_max;
    } t_cfg;

    typedef struct packed {
        t_err_code             err;
        logic [FRAME_BITS-1:0] bits;
        logic                  dim_given;
    } t_frame;

endpackage

// ----- rtl/core/ookd_cmd_if.sv -----
// command channel interface
`timescale 1ns / 1ps
interface ookd_cmd_if;
    import ookd_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   device_id;
    logic              id_given;
    logic [UNIT_W-1:0] unit_code;
    logic              unit_given;
    logic              all_units;
    logic [CMD_W-1:0]  switch_cmd;
    logic [DIM_W-1:0]  dim_level;
    logic              dim_given;

    modport source (
        output valid, device_id, id_given, unit_code, unit_given, all_units,
               switch_cmd, dim_level, dim_given,
        input  ready
    );

    modport sink (
        input  valid, device_id, id_given, unit_code, unit_given, all_units,
               switch_cmd, dim_level, dim_given,
        output ready
    );
endinterface

// ----- rtl/core/ookd_sym_if.sv -----
// symbol channel interface
`timescale 1ns / 1ps
interface ookd_sym_if;
    import ookd_pkg::*;

    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_a;
    logic [PULSE_W-1:0] pulse_b;
    logic [PULSE_W-1:0] pulse_c;
    logic [PULSE_W-1:0] pulse_d;
    logic [COUNT_W-1:0] pulse_count;
    logic [ERR_W-1:0]   error_code;
    logic               last;

    modport source (
        output valid, pulse_a, pulse_b, pulse_c, pulse_d, pulse_count, error_code, last,
        input  ready
    );

    modport sink (
        input  valid, pulse_a, pulse_b, pulse_c, pulse_d, pulse_count, error_code, last,
        output ready
    );
endinterface

// ----- rtl/core/ookd_cfg_regs.sv -----
// configuration registers and derived pulse durations
`timescale 1ns / 1ps
module ookd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ookd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ookd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ookd_pkg::t_cfg                 o_cfg
);
    import ookd_pkg::*;

    logic [BASE_W-1:0]   r_base_pulse;
    logic [FACTOR_W-1:0] r_long_factor;
    logic [FACTOR_W-1:0] r_footer_factor;
    logic [DIM_W-1:0]    r_dim_min;
    logic [DIM_W-1:0]    r_dim_max;
    t_cfg                r_cfg;
    t_cfg                n_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_pulse    <= BASE_PULSE_RST;
            r_long_factor   <= LONG_FACTOR_RST;
            r_footer_factor <= FOOTER_FACTOR_RST;
            r_dim_min       <= DIM_MIN_RST;
            r_dim_max       <= DIM_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_PULSE:    r_base_pulse    <= i_cfg_data[BASE_W-1:0];
                CFG_LONG_FACTOR:   r_long_factor   <= i_cfg_data[FACTOR_W-1:0];
                CFG_FOOTER_FACTOR: r_footer_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_DIM_MIN:       r_dim_min       <= i_cfg_data[DIM_W-1:0];
                CFG_DIM_MAX:       r_dim_max       <= i_cfg_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_cfg.short_pulse  = PULSE_W'(r_base_pulse);
        n_cfg.start_pulse  = PULSE_W'(r_base_pulse) * PULSE_W'(START_FACTOR);
        n_cfg.long_pulse   = PULSE_W'(r_long_factor) * PULSE_W'(r_base_pulse);
        n_cfg.footer_pulse = PULSE_W'(r_footer_factor) * PULSE_W'(r_base_pulse);
        n_cfg.dim_min      = r_dim_min;
        n_cfg.dim_max      = r_dim_max;
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_cfg = r_cfg;
endmodule

// ----- rtl/core/ookd_check.sv -----
// command checks and frame bit assembly
`timescale 1ns / 1ps
module ookd_check (
    input  ookd_pkg::t_cmd              i_cmd,
    input  logic [ookd_pkg::DIM_W-1:0]  i_dim_min,
    input  logic [ookd_pkg::DIM_W-1:0]  i_dim_max,
    output ookd_pkg::t_frame            o_frame
);
    import ookd_pkg::*;

    logic is_off;
    logic is_on;

    assign is_off = (i_cmd.switch_cmd == CMD_OFF);
    assign is_on  = (i_cmd.switch_cmd == CMD_ON);

    always_comb begin
        if (!i_cmd.id_given || (!i_cmd.unit_given && !i_cmd.all_units) ||
            (!i_cmd.dim_given && !is_off && !is_on)) begin
            o_frame.err = ERR_MISSING;
        end else if (i_cmd.device_id == '0) begin
            o_frame.err = ERR_BAD_ID;
        end else if (i_cmd.dim_given &&
                     (i_cmd.dim_level < i_dim_min || i_cmd.dim_level > i_dim_max)) begin
            o_frame.err = ERR_BAD_DIM;
        end else if (i_cmd.dim_given && is_off) begin
            o_frame.err = ERR_DIM_OFF;
        end else begin
            o_frame.err = ERR_NONE;
        end
        o_frame.bits = {i_cmd.device_id,
                        i_cmd.all_units,
                        is_on && !i_cmd.dim_given,
                        i_cmd.unit_given ? i_cmd.unit_code : UNIT_W'(0),
                        i_cmd.dim_given ? i_cmd.dim_level : DIM_W'(0)};
        o_frame.dim_given = i_cmd.dim_given;
    end
endmodule

// ----- rtl/core/ookd_symbol_gen.sv -----
// symbol sequencer with output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ookd_symbol_gen (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ookd_pkg::t_cfg   i_cfg,
    input  logic             i_frame_valid,
    output logic             o_frame_ready,
    input  ookd_pkg::t_frame i_frame,
    ookd_sym_if.source       o_sym
);
    import ookd_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOL_COUNT - 1);

    logic               r_busy;
    t_frame             r_frame;
    logic [IDX_W-1:0]   r_idx;
    logic               r_out_valid;
    logic [PULSE_W-1:0] r_pulse_a;
    logic [PULSE_W-1:0] r_pulse_b;
    logic [PULSE_W-1:0] r_pulse_c;
    logic [PULSE_W-1:0] r_pulse_d;
    logic [COUNT_W-1:0] r_count;
    logic [ERR_W-1:0]   r_err;
    logic               r_last;

    logic [PULSE_W-1:0] n_pulse_a;
    logic [PULSE_W-1:0] n_pulse_b;
    logic [PULSE_W-1:0] n_pulse_c;
    logic [PULSE_W-1:0] n_pulse_d;
    logic [COUNT_W-1:0] n_count;
    logic               n_last;
    logic [IDX_W-1:0]   group_idx;
    logic [IDX_W-1:0]   bit_pos;
    logic               adv;
    logic               sym_last;
    logic               frame_take;

    assign adv        = r_busy && (!r_out_valid || o_sym.ready);
    assign sym_last   = (r_frame.err != ERR_NONE) || (r_idx == LAST_IDX);
    assign o_frame_ready = !r_busy || (adv && sym_last);
    assign frame_take = i_frame_valid && o_frame_ready;
    assign group_idx  = r_idx - IDX_W'(1);
    assign bit_pos    = IDX_W'(FRAME_BITS - 1) - group_idx;

    always_comb begin
        n_pulse_a = '0;
        n_pulse_b = '0;
        n_pulse_c = '0;
        n_pulse_d = '0;
        n_count   = COUNT_NONE;
        n_last    = 1'b0;
        if (r_frame.err != ERR_NONE) begin
            n_last = 1'b1;
        end else if (r_idx == '0) begin
            n_pulse_a = i_cfg.short_pulse;
            n_pulse_b = i_cfg.start_pulse;
            n_count   = COUNT_PAIR;
        end else if (r_idx == LAST_IDX) begin
            n_pulse_a = i_cfg.short_pulse;
            n_pulse_b = i_cfg.footer_pulse;
            n_count   = COUNT_PAIR;
            n_last    = 1'b1;
        end else begin
            n_pulse_a = i_cfg.short_pulse;
            n_pulse_c = i_cfg.short_pulse;
            n_count   = COUNT_QUAD;
            if (group_idx == IDX_W'(STATE_GROUP) && r_frame.dim_given) begin
                n_pulse_b = i_cfg.short_pulse;
                n_pulse_d = i_cfg.short_pulse;
            end else if (r_frame.bits[bit_pos]) begin
                n_pulse_b = i_cfg.long_pulse;
                n_pulse_d = i_cfg.short_pulse;
            end else begin
                n_pulse_b = i_cfg.short_pulse;
                n_pulse_d = i_cfg.long_pulse;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (frame_take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv) begin
                if (sym_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_sym.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_take) begin
            r_frame <= i_frame;
        end
        if (adv) begin
            r_pulse_a <= n_pulse_a;
            r_pulse_b <= n_pulse_b;
            r_pulse_c <= n_pulse_c;
            r_pulse_d <= n_pulse_d;
            r_count   <= n_count;
            r_err     <= r_frame.err;
            r_last    <= n_last;
        end
    end

    assign o_sym.valid       = r_out_valid;
    assign o_sym.pulse_a     = r_pulse_a;
    assign o_sym.pulse_b     = r_pulse_b;
    assign o_sym.pulse_c     = r_pulse_c;
    assign o_sym.pulse_d     = r_pulse_d;
    assign o_sym.pulse_count = r_count;
    assign o_sym.error_code  = r_err;
    assign o_sym.last        = r_last;

    `ASSERT_CLK(a_idx_range, r_idx <= LAST_IDX, "symbol index beyond frame end")
    `ASSERT_CLK(a_err_single, r_out_valid && (r_err != ERR_NONE) |-> r_last && (r_count == COUNT_NONE),
                "error result not single")
    `ASSERT_CLK(a_busy_holds, adv && !sym_last |=> r_busy, "frame dropped before its last symbol")
    `ASSERT_RST(a_reset_idle, !i_rst_n |=> !r_out_valid && !r_busy, "not idle after reset")
endmodule

// ----- rtl/core/ook_dimmer_frame_encoder_core.sv -----
// top level of the ook dimmer frame encoder
//
// i_cmd carries one remote-switch command per transfer; o_sym carries the
// resulting symbols, one per transfer, with last set on the final one.
// A command that fails its checks gives a single transfer with the error
// code, zero pulses and last set. A valid command gives 38 transfers: the
// start pair, 36 four-pulse bit groups and the end pair with the footer.
// A command is held in an input register, checked and loaded into the
// sequencer once it is free; its symbols go out through the output
// register. The sequencer emits one symbol per cycle while the receiver
// accepts them, so a valid command occupies it for all 38 symbols and an
// invalid one for its single symbol; the next command is loaded in the
// cycle of the previous last symbol, so symbols follow without gaps. When
// the receiver stalls, the output register holds its symbol and the
// sequencer and then the input register stop. Configuration writes on
// i_cfg_we take effect once the derived pulse lengths are registered; the
// user must make them only while idle, which the block does not enforce.
// Reset restores the default register values and empties all stages.
`timescale 1ns / 1ps
module ook_dimmer_frame_encoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ookd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ookd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ookd_cmd_if.sink                        i_cmd,
    ookd_sym_if.source                      o_sym
);
    import ookd_pkg::*;

    logic   r_in_valid;
    t_cmd   r_in;
    t_cfg   cfg;
    t_frame frame;
    logic   frame_ready;

    assign i_cmd.ready = !r_in_valid || frame_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_valid <= 1'b1;
        end else if (frame_ready) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in.device_id  <= i_cmd.device_id;
            r_in.id_given   <= i_cmd.id_given;
            r_in.unit_code  <= i_cmd.unit_code;
            r_in.unit_given <= i_cmd.unit_given;
            r_in.all_units  <= i_cmd.all_units;
            r_in.switch_cmd <= i_cmd.switch_cmd;
            r_in.dim_level  <= i_cmd.dim_level;
            r_in.dim_given  <= i_cmd.dim_given;
        end
    end

    ookd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ookd_check u_check (
        .i_cmd     (r_in),
        .i_dim_min (cfg.dim_min),
        .i_dim_max (cfg.dim_max),
        .o_frame   (frame)
    );

    ookd_symbol_gen u_gen (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_frame_valid (r_in_valid),
        .o_frame_ready (frame_ready),
        .i_frame       (frame),
        .o_sym         (o_sym)
    );
endmodule
